// ===== rtl/isolated_pixel_removal_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the isolated pixel removal block
// Each macro expects clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef ISOLATED_PIXEL_REMOVAL_DEFINES_SVH
`define ISOLATED_PIXEL_REMOVAL_DEFINES_SVH

// Condition holds at every edge out of reset.
`define IPR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ipr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared types and constants of the isolated pixel removal block.
// ----------------------------------------------------------------------------
package ipr_pkg;

    localparam int PIXEL_W     = 32;
    localparam int COLUMN_W    = 12;
    localparam int ROW_W       = 10;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;

    // result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STG_NONE,
        STG_PIXEL,
        STG_DRAIN
    } stage_kind_t;

    typedef struct packed
    {
        logic [PIXEL_W-1:0]  pixel;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic                replaced;
        logic                frame_done;
    } result_t;

endpackage

// ===== rtl/ipr_hist_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_hist_bank
// One column bank of pixel history: one write and one registered read per
// cycle; a read of the entry written at the same edge returns the new word.
// ----------------------------------------------------------------------------
module ipr_hist_bank #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [ipr_pkg::PIXEL_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [ipr_pkg::PIXEL_W-1:0] rd_data
);

    logic [ipr_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [ipr_pkg::PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ipr_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_out_fifo
// Small result queue between the decision stage and the output channel.
// ----------------------------------------------------------------------------
`include "isolated_pixel_removal_defines.svh"

module ipr_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipr_pkg::result_t  push_data,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_stall,
    output ipr_pkg::result_t  head
);

    localparam int CNT_W = ipr_pkg::OUT_PTR_W + 1;

    ipr_pkg::result_t                entry [ipr_pkg::OUT_DEPTH];
    logic [ipr_pkg::OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [ipr_pkg::OUT_PTR_W-1:0]   wr_ptr_next;
    logic [ipr_pkg::OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [ipr_pkg::OUT_PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic                            pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = entry[rd_ptr_reg];
    // the word in the decision stage counts as already taken
    assign has_room  = ((count_reg + CNT_W'(push)) < CNT_W'(ipr_pkg::OUT_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    `IPR_ASSERT(a_fifo_no_overflow, !(push && !pop && (count_reg == CNT_W'(ipr_pkg::OUT_DEPTH))), "result queue overflow")

endmodule

// ===== rtl/isolated_pixel_removal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isolated_pixel_removal
// Four-neighbour island filter on a column-major ARGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): op = pixel carries the next pixel in
//    column-major order, op = drain is a flush tick. A request is taken at an
//    edge with in_valid high and in_stall low.
//  - Output channel (out_valid / out_stall): one result per finalised pixel,
//    with its column, row, replaced flag and frame_done on the last pixel.
//  - Pixel (x,y) is decided when pixel (x+1,y) arrives; its result goes
//    through the decision stage and the result queue to the output. The last
//    column is flushed by one drain tick per row once the whole frame is in.
//  - Throughput: one request per cycle unless in_stall is high, set by the
//    single read and write port of each history bank (one per column parity).
//  - Geometry is written through cfg_write / cfg_index / cfg_data while the
//    block is idle; a write to either geometry register restarts the frame.
//  - Reset clears the counters and the queue; the history banks are not
//    cleared, which is harmless as no entry is read before it is written.
//  - When the receiver stalls, results collect in a four-entry queue and
//    in_stall rises once the queue and the word in flight would fill it.
// ----------------------------------------------------------------------------
`include "isolated_pixel_removal_defines.svh"

module isolated_pixel_removal #(
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WIDTH  = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [ipr_pkg::PIXEL_W-1:0]       pixel_in,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ipr_pkg::PIXEL_W-1:0]       pixel_out,
    output logic [ipr_pkg::COLUMN_W-1:0]      out_column,
    output logic [ipr_pkg::ROW_W-1:0]         out_row,
    output logic                              replaced,
    output logic                              frame_done,
    // configuration
    input  logic                              cfg_write,
    input  logic [ipr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ipr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int RST_W_EFF = (ipr_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                               MAX_WIDTH : ipr_pkg::RESET_FRAME_WIDTH;
    localparam int RST_H_EFF = (ipr_pkg::RESET_FRAME_HEIGHT > MAX_HEIGHT) ?
                               MAX_HEIGHT : ipr_pkg::RESET_FRAME_HEIGHT;
    localparam logic [CW-1:0] RST_WLAST = CW'(RST_W_EFF - 1);
    localparam logic [RW-1:0] RST_HLAST = RW'(RST_H_EFF - 1);

    // ------------------------------------------------------------------
    // Geometry, held as last column / last row after clamping
    // ------------------------------------------------------------------
    logic [CW-1:0] wlast_reg;
    logic [CW-1:0] wlast_next;
    logic [RW-1:0] hlast_reg;
    logic [RW-1:0] hlast_next;
    logic [CW-1:0] wlast_cfg;
    logic [RW-1:0] hlast_cfg;
    logic [10:0]   height_data;
    logic          cfg_restart;

    assign height_data = cfg_data[10:0];
    assign cfg_restart = cfg_write && ((cfg_index == ipr_pkg::REG_FRAME_WIDTH) ||
                                       (cfg_index == ipr_pkg::REG_FRAME_HEIGHT));

    always_comb
    begin
        if (cfg_data == '0)
            wlast_cfg = '0;
        else if (32'(cfg_data) > MAX_WIDTH)
            wlast_cfg = CW'(MAX_WIDTH - 1);
        else
            wlast_cfg = CW'(cfg_data - 1'b1);

        if (height_data == '0)
            hlast_cfg = '0;
        else if (32'(height_data) > MAX_HEIGHT)
            hlast_cfg = RW'(MAX_HEIGHT - 1);
        else
            hlast_cfg = RW'(height_data - 1'b1);

        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        if (cfg_write && (cfg_index == ipr_pkg::REG_FRAME_WIDTH))
            wlast_next = wlast_cfg;
        if (cfg_write && (cfg_index == ipr_pkg::REG_FRAME_HEIGHT))
            hlast_next = hlast_cfg;
    end

    // ------------------------------------------------------------------
    // Request stage: position counters and history reads
    // ------------------------------------------------------------------
    logic [CW-1:0] tk_col_reg;      // column of the next pixel to take
    logic [CW-1:0] tk_col_next;
    logic [RW-1:0] tk_row_reg;
    logic [RW-1:0] tk_row_next;
    logic          full_reg;        // whole frame taken, waiting for drain
    logic          full_next;
    logic [RW-1:0] dr_row_reg;      // next last-column row to flush
    logic [RW-1:0] dr_row_next;

    logic in_acc;
    logic take_pixel;
    logic take_drain;
    logic last_row;
    logic frame_end;
    logic fifo_room;

    assign in_stall   = !fifo_room;
    assign in_acc     = in_valid && !in_stall;
    assign take_pixel = in_acc && (ipr_pkg::op_t'(op) == ipr_pkg::OP_PIXEL) && !full_reg;
    assign take_drain = in_acc && (ipr_pkg::op_t'(op) == ipr_pkg::OP_DRAIN) && full_reg;
    assign last_row   = (tk_row_reg == hlast_reg);
    assign frame_end  = (dr_row_reg == hlast_reg);

    always_comb
    begin
        tk_col_next = tk_col_reg;
        tk_row_next = tk_row_reg;
        full_next   = full_reg;
        dr_row_next = dr_row_reg;
        if (cfg_restart)
        begin
            tk_col_next = '0;
            tk_row_next = '0;
            full_next   = 1'b0;
            dr_row_next = '0;
        end
        else if (take_pixel)
        begin
            if (last_row)
            begin
                tk_row_next = '0;
                if (tk_col_reg == wlast_reg)
                begin
                    tk_col_next = '0;
                    full_next   = 1'b1;
                end
                else
                begin
                    tk_col_next = tk_col_reg + 1'b1;
                end
            end
            else
            begin
                tk_row_next = tk_row_reg + 1'b1;
            end
        end
        else if (take_drain)
        begin
            if (frame_end)
            begin
                // frame complete: everything restarts
                tk_col_next = '0;
                tk_row_next = '0;
                full_next   = 1'b0;
                dr_row_next = '0;
            end
            else
            begin
                dr_row_next = dr_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg  <= RST_WLAST;
            hlast_reg  <= RST_HLAST;
            tk_col_reg <= '0;
            tk_row_reg <= '0;
            full_reg   <= 1'b0;
            dr_row_reg <= '0;
        end
        else
        begin
            wlast_reg  <= wlast_next;
            hlast_reg  <= hlast_next;
            tk_col_reg <= tk_col_next;
            tk_row_reg <= tk_row_next;
            full_reg   <= full_next;
            dr_row_reg <= dr_row_next;
        end
    end

    // Bank A holds the incoming column (and, before the overwrite, the left
    // neighbour); bank B holds the column being decided. On the last row,
    // bank A fetches row 0 of the incoming column, the next column's centre.
    logic [RW-1:0] addr_a;
    logic [RW-1:0] addr_b;
    logic [RW-1:0] rd0_addr;
    logic [RW-1:0] rd1_addr;
    logic          rd_en;

    assign addr_a = last_row ? '0 : tk_row_reg;
    assign addr_b = last_row ? '0 : RW'(tk_row_reg + 1'b1);
    assign rd_en  = take_pixel || take_drain;

    always_comb
    begin
        if (take_drain)
        begin
            rd0_addr = dr_row_reg;
            rd1_addr = dr_row_reg;
        end
        else if (tk_col_reg[0])
        begin
            rd0_addr = addr_b;
            rd1_addr = addr_a;
        end
        else
        begin
            rd0_addr = addr_a;
            rd1_addr = addr_b;
        end
    end

    // ------------------------------------------------------------------
    // Decision stage
    // ------------------------------------------------------------------
    ipr_pkg::stage_kind_t        s2_kind_reg;
    ipr_pkg::stage_kind_t        s2_kind_next;
    logic                        s2_par_reg;      // parity of bank A
    logic [ipr_pkg::PIXEL_W-1:0] s2_px_reg;
    logic [CW-1:0]               s2_col_reg;
    logic [RW-1:0]               s2_row_reg;
    logic                        s2_emit_reg;
    logic                        s2_interior_reg;
    logic                        s2_last_reg;
    logic                        s2_single_reg;
    logic                        s2_done_reg;
    logic [ipr_pkg::PIXEL_W-1:0] cur_reg;         // centre pixel
    logic [ipr_pkg::PIXEL_W-1:0] cur_next;
    logic [ipr_pkg::PIXEL_W-1:0] above_reg;       // final value of row above

    always_comb
    begin
        if (take_pixel)
            s2_kind_next = ipr_pkg::STG_PIXEL;
        else if (take_drain)
            s2_kind_next = ipr_pkg::STG_DRAIN;
        else
            s2_kind_next = ipr_pkg::STG_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_kind_reg <= ipr_pkg::STG_NONE;
        else
            s2_kind_reg <= s2_kind_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s2_par_reg      <= take_drain ? wlast_reg[0] : tk_col_reg[0];
            s2_px_reg       <= pixel_in;
            s2_col_reg      <= take_drain ? wlast_reg : CW'(tk_col_reg - 1'b1);
            s2_row_reg      <= take_drain ? dr_row_reg : tk_row_reg;
            s2_emit_reg     <= (tk_col_reg != '0);
            s2_interior_reg <= (tk_col_reg > CW'(1)) && (tk_row_reg != '0) && !last_row;
            s2_last_reg     <= last_row;
            s2_single_reg   <= (hlast_reg == '0);
            s2_done_reg     <= frame_end;
        end
    end

    logic [ipr_pkg::PIXEL_W-1:0] rd0_data;
    logic [ipr_pkg::PIXEL_W-1:0] rd1_data;
    logic [ipr_pkg::PIXEL_W-1:0] rd_a;            // left, or drained word
    logic [ipr_pkg::PIXEL_W-1:0] rd_b;            // below
    logic [ipr_pkg::PIXEL_W-1:0] final_px;
    logic                        s2_pixel;
    logic                        s2_drain;
    logic                        rep;
    logic                        wr0_en;
    logic                        wr1_en;
    logic [ipr_pkg::PIXEL_W-1:0] wr0_data;
    logic [ipr_pkg::PIXEL_W-1:0] wr1_data;
    logic                        push;
    ipr_pkg::result_t            push_data;
    ipr_pkg::result_t            head;

    assign s2_pixel = (s2_kind_reg == ipr_pkg::STG_PIXEL);
    assign s2_drain = (s2_kind_reg == ipr_pkg::STG_DRAIN);
    assign rd_a     = s2_par_reg ? rd1_data : rd0_data;
    assign rd_b     = s2_par_reg ? rd0_data : rd1_data;

    // island: centre differs from the four neighbours, which all agree
    assign rep = s2_pixel && s2_interior_reg && (cur_reg != rd_a) &&
                 (rd_a == s2_px_reg) && (rd_a == above_reg) && (rd_a == rd_b);
    assign final_px = rep ? rd_a : cur_reg;

    // new pixel to bank A, corrected centre to bank B
    assign wr0_en   = s2_pixel && (!s2_par_reg || rep);
    assign wr1_en   = s2_pixel && (s2_par_reg || rep);
    assign wr0_data = s2_par_reg ? rd_a : s2_px_reg;
    assign wr1_data = s2_par_reg ? s2_px_reg : rd_a;

    assign push = (s2_pixel && s2_emit_reg) || s2_drain;

    always_comb
    begin
        push_data.column     = ipr_pkg::COLUMN_W'(s2_col_reg);
        push_data.row        = ipr_pkg::ROW_W'(s2_row_reg);
        if (s2_drain)
        begin
            push_data.pixel      = rd_a;
            push_data.replaced   = 1'b0;
            push_data.frame_done = s2_done_reg;
        end
        else
        begin
            push_data.pixel      = final_px;
            push_data.replaced   = rep;
            push_data.frame_done = 1'b0;
        end

        if (!s2_last_reg)
            cur_next = rd_b;
        else if (s2_single_reg)
            cur_next = s2_px_reg;
        else
            cur_next = rd_a;
    end

    always_ff @(posedge clk)
    begin
        if (s2_pixel)
        begin
            cur_reg   <= cur_next;
            above_reg <= final_px;
        end
    end

    // ------------------------------------------------------------------
    // History banks and result queue
    // ------------------------------------------------------------------
    ipr_hist_bank #(
        .DEPTH  (MAX_HEIGHT),
        .ADDR_W (RW)
    ) u_bank_even (
        .clk     (clk),
        .wr_en   (wr0_en),
        .wr_addr (s2_row_reg),
        .wr_data (wr0_data),
        .rd_en   (rd_en),
        .rd_addr (rd0_addr),
        .rd_data (rd0_data)
    );

    ipr_hist_bank #(
        .DEPTH  (MAX_HEIGHT),
        .ADDR_W (RW)
    ) u_bank_odd (
        .clk     (clk),
        .wr_en   (wr1_en),
        .wr_addr (s2_row_reg),
        .wr_data (wr1_data),
        .rd_en   (rd_en),
        .rd_addr (rd1_addr),
        .rd_data (rd1_data)
    );

    ipr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .has_room  (fifo_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign pixel_out  = head.pixel;
    assign out_column = head.column;
    assign out_row    = head.row;
    assign replaced   = head.replaced;
    assign frame_done = head.frame_done;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `IPR_ASSERT(a_full_parks_counter, !full_reg || ((tk_col_reg == '0) && (tk_row_reg == '0)), "take counter not parked while frame is full")
    `IPR_ASSERT(a_drain_needs_full, (dr_row_reg == '0) || full_reg, "drain row advanced without a full frame")
    `IPR_ASSERT_NEXT(a_frame_restart, take_drain && frame_end, !full_reg && (dr_row_reg == '0) && s2_drain && s2_done_reg, "frame end did not restart counters")

endmodule
